[src/gb5_pkg.sv]
// Shared types and constants for the 5x5 Gaussian blur.
// No dependencies; used by every module of the block by scoped names.
`timescale 1ns / 1ps

package gb5_pkg;

  localparam int PIX_W     = 8;
  localparam int CFG_W     = 11;
  localparam int LS_ROWS   = 4;               // rows held above the current one
  localparam int LS_W      = LS_ROWS * PIX_W; // one line-store word per column
  localparam int COLSUM_W  = 12;              // 12 * 255 = 3060
  localparam int HSUM_W    = 16;              // 144 * 255 = 36720
  localparam int DIM_MIN   = 5;
  localparam int DIM_RESET = 1024;

  // sum / 144 == (sum >> 4) / 9; the /9 is a multiply by ceil(2^16 / 9)
  localparam int DIV_PRE_SHIFT = 4;
  localparam int DIV_Q_W       = HSUM_W - DIV_PRE_SHIFT;
  localparam int DIV_RECIP_W   = 13;
  localparam logic [DIV_RECIP_W-1:0] DIV_RECIP = 13'd7282;
  localparam int DIV_SHIFT     = 16;

  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  // One window column, reduced to its vertical weighted sum.
  typedef struct packed {
    logic [COLSUM_W-1:0] colsum;
    logic                emit;
    logic                margin;
    logic                last;
  } col_beat_t;

endpackage

[src/gaussian_blur_5x5.sv]
// 5x5 Gaussian blur (kernel 1,3,4,3,1 outer product, /144) on a raster stream.
// One pixel per clock while in_stall is low; a result beat passes the line-store
// read, column sum, window sum and divide registers after its pixel is accepted.
// After reset the line store sweeps all MAX_WIDTH entries to zero with in_stall
// high; config writes are taken during the sweep.
// Depends on gb5_pkg, gb5_line_store, gb5_hsum.
`timescale 1ns / 1ps

module gaussian_blur_5x5 #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [gb5_pkg::PIX_W-1:0]     pixel,
  input  logic                          frame_start,
  input  logic                          in_valid,
  output logic                          in_stall,
  output logic [gb5_pkg::PIX_W-1:0]     blurred,
  output logic                          in_margin,
  output logic                          frame_last,
  output logic                          out_valid,
  input  logic                          out_stall,
  input  logic                          cfg_write,
  input  logic [0:0]                    cfg_index,
  input  logic [gb5_pkg::CFG_W-1:0]     cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int XW = ($clog2(MAX_WIDTH + 1) > gb5_pkg::CFG_W) ?
                      $clog2(MAX_WIDTH + 1) : gb5_pkg::CFG_W;
  localparam int YW = ($clog2(MAX_HEIGHT + 1) > gb5_pkg::CFG_W) ?
                      $clog2(MAX_HEIGHT + 1) : gb5_pkg::CFG_W;
  localparam int W_LAST_RST = ((gb5_pkg::DIM_RESET > MAX_WIDTH) ?
                               MAX_WIDTH : gb5_pkg::DIM_RESET) - 1;
  localparam int H_LAST_RST = ((gb5_pkg::DIM_RESET > MAX_HEIGHT) ?
                               MAX_HEIGHT : gb5_pkg::DIM_RESET) - 1;

  // Config, kept as clamped (dimension - 1)
  logic [XW-1:0] w_last;
  logic [YW-1:0] h_last;
  logic [XW-1:0] cfg_w;
  logic [YW-1:0] cfg_h;

  // Position of the next pixel
  logic [CW-1:0] col_count;
  logic [RW-1:0] row_count;
  logic [CW-1:0] c_cur;
  logic [RW-1:0] r_cur;
  logic          line_end;
  logic          frame_end;
  logic          in_acc;

  // Stage 1: line-store data arrives
  logic                      s1_valid;
  logic [gb5_pkg::PIX_W-1:0] s1_px;
  logic [CW-1:0]             s1_c;
  logic                      s1_emit;
  logic                      s1_margin;
  logic                      s1_last;
  logic                      s1_go;

  logic [gb5_pkg::LS_W-1:0]  ls_rd;
  logic [gb5_pkg::LS_W-1:0]  ls_wr;
  logic                      ls_busy;
  logic                      hs_ready;
  gb5_pkg::col_beat_t        col_beat;
  logic [gb5_pkg::COLSUM_W-1:0] b0, b1, b2, b3, bp;

  assign cfg_w = XW'(cfg_data);
  assign cfg_h = YW'(cfg_data);

  always_ff @(posedge clk) begin
    if (rst) begin
      w_last <= XW'(W_LAST_RST);
      h_last <= YW'(H_LAST_RST);
    end else if (cfg_write) begin
      unique case (gb5_pkg::cfg_reg_t'(cfg_index))
        gb5_pkg::REG_FRAME_WIDTH: begin
          if (cfg_w < XW'(gb5_pkg::DIM_MIN)) begin
            w_last <= XW'(gb5_pkg::DIM_MIN - 1);
          end else if (cfg_w > XW'(MAX_WIDTH)) begin
            w_last <= XW'(MAX_WIDTH - 1);
          end else begin
            w_last <= cfg_w - XW'(1);
          end
        end
        gb5_pkg::REG_FRAME_HEIGHT: begin
          if (cfg_h < YW'(gb5_pkg::DIM_MIN)) begin
            h_last <= YW'(gb5_pkg::DIM_MIN - 1);
          end else if (cfg_h > YW'(MAX_HEIGHT)) begin
            h_last <= YW'(MAX_HEIGHT - 1);
          end else begin
            h_last <= cfg_h - YW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign in_stall  = ls_busy || (s1_valid && !hs_ready);
  assign in_acc    = in_valid && !in_stall;
  assign c_cur     = frame_start ? '0 : col_count;
  assign r_cur     = frame_start ? '0 : row_count;
  assign line_end  = XW'(c_cur) >= w_last;
  assign frame_end = line_end && (YW'(r_cur) >= h_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (in_acc) begin
      if (line_end) begin
        col_count <= '0;
        row_count <= frame_end ? '0 : r_cur + RW'(1);
      end else begin
        col_count <= c_cur + CW'(1);
        row_count <= r_cur;
      end
    end
  end

  assign s1_go = s1_valid && hs_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!s1_valid || hs_ready) begin
      s1_valid <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_px     <= pixel;
      s1_c      <= c_cur;
      s1_emit   <= (r_cur >= RW'(2)) && (c_cur >= CW'(2));
      s1_margin <= (r_cur < RW'(4)) || (c_cur < CW'(4));
      s1_last   <= frame_end;
    end
  end

  // Byte k of a word is the row k+1 above; shift down and put the new pixel in byte 0.
  assign ls_wr = {ls_rd[gb5_pkg::LS_W-gb5_pkg::PIX_W-1:0], s1_px};

  gb5_line_store #(
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (in_acc),
    .rd_addr (c_cur),
    .rd_data (ls_rd),
    .wr_en   (s1_go),
    .wr_addr (s1_c),
    .wr_data (ls_wr),
    .busy    (ls_busy)
  );

  // Vertical taps 1,3,4,3,1 from oldest row to the new pixel
  always_comb begin
    b0 = gb5_pkg::COLSUM_W'(ls_rd[0 +: gb5_pkg::PIX_W]);
    b1 = gb5_pkg::COLSUM_W'(ls_rd[gb5_pkg::PIX_W +: gb5_pkg::PIX_W]);
    b2 = gb5_pkg::COLSUM_W'(ls_rd[2 * gb5_pkg::PIX_W +: gb5_pkg::PIX_W]);
    b3 = gb5_pkg::COLSUM_W'(ls_rd[3 * gb5_pkg::PIX_W +: gb5_pkg::PIX_W]);
    bp = gb5_pkg::COLSUM_W'(s1_px);
    col_beat.colsum = b3 + (b2 << 1) + b2 + (b1 << 2) + (b0 << 1) + b0 + bp;
    col_beat.emit   = s1_emit;
    col_beat.margin = s1_margin;
    col_beat.last   = s1_last;
  end

  gb5_hsum u_hsum (
    .clk        (clk),
    .rst        (rst),
    .col_valid  (s1_valid),
    .col_beat   (col_beat),
    .col_ready  (hs_ready),
    .blurred    (blurred),
    .in_margin  (in_margin),
    .frame_last (frame_last),
    .out_valid  (out_valid),
    .out_stall  (out_stall)
  );

  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    (in_acc && frame_end) |=> ((col_count == '0) && (row_count == '0)))
    else $error("position did not wrap at end of frame");

  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    XW'(col_count) < XW'(MAX_WIDTH))
    else $error("column counter beyond line store depth");

  a_stage1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !hs_ready) |=> (s1_valid && $stable(s1_c) && $stable(ls_rd)))
    else $error("stage 1 beat changed while held");

endmodule

[src/gb5_line_store.sv]
// Line store: four previous rows packed one word per column, sync read.
// Same-address write/read in one cycle is forwarded. Clears itself after reset.
`timescale 1ns / 1ps

module gb5_line_store #(
  parameter int DEPTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          rd_en,
  input  logic [$clog2(DEPTH)-1:0]      rd_addr,
  output logic [gb5_pkg::LS_W-1:0]      rd_data,
  input  logic                          wr_en,
  input  logic [$clog2(DEPTH)-1:0]      wr_addr,
  input  logic [gb5_pkg::LS_W-1:0]      wr_data,
  output logic                          busy
);

  localparam int AW = $clog2(DEPTH);

  logic [gb5_pkg::LS_W-1:0] mem [DEPTH];
  logic [AW-1:0]            clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      if (clr_addr == AW'(DEPTH - 1)) begin
        busy <= 1'b0;
      end
      clr_addr <= clr_addr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data <= wr_data;
      end else begin
        rd_data <= mem[rd_addr];
      end
    end
  end

  a_no_access_while_clearing: assert property (@(posedge clk) disable iff (rst)
    busy |-> (!rd_en && !wr_en))
    else $error("line store accessed during clear pass");

  a_clear_ends_at_top: assert property (@(posedge clk) disable iff (rst)
    ($past(busy) && !busy) |-> (clr_addr == '0))
    else $error("clear pass ended before sweeping every entry");

  a_forward_hit: assert property (@(posedge clk) disable iff (rst)
    (!busy && rd_en && wr_en && (wr_addr == rd_addr)) |=> (rd_data == $past(wr_data)))
    else $error("line store forwarding missed a same-column write");

endmodule

[src/gb5_hsum.sv]
// Horizontal stage: keeps the last four column sums, forms the 5x5 weighted
// sum, divides by 144 and holds the result beat. Depends on gb5_pkg.
`timescale 1ns / 1ps

module gb5_hsum (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          col_valid,
  input  gb5_pkg::col_beat_t            col_beat,
  output logic                          col_ready,
  output logic [gb5_pkg::PIX_W-1:0]     blurred,
  output logic                          in_margin,
  output logic                          frame_last,
  output logic                          out_valid,
  input  logic                          out_stall
);

  localparam int SW = gb5_pkg::HSUM_W;
  localparam int PW = gb5_pkg::DIV_Q_W + gb5_pkg::DIV_RECIP_W;

  gb5_pkg::col_beat_t        s2_beat;
  logic                      s2_valid;
  logic [gb5_pkg::COLSUM_W-1:0] cs [4];    // cs[3] is the newest column

  logic                      s3_valid;
  logic                      s3_margin;
  logic                      s3_last;
  logic [SW-1:0]             s3_sum;

  logic                      o_free;
  logic                      s3_free;
  logic                      s2_go;
  logic [SW-1:0]             t0, t1, t2, t3, t4;
  logic [SW-1:0]             hsum;
  logic [gb5_pkg::DIV_Q_W-1:0] div_in;
  logic [PW-1:0]             div_prod;
  logic [gb5_pkg::PIX_W-1:0] quot;

  assign o_free    = !out_valid || !out_stall;
  assign s3_free   = !s3_valid || o_free;
  assign s2_go     = s2_valid && (!s2_beat.emit || s3_free);
  assign col_ready = !s2_valid || s2_go;

  always_comb begin
    t0   = SW'(cs[0]);
    t1   = SW'(cs[1]);
    t2   = SW'(cs[2]);
    t3   = SW'(cs[3]);
    t4   = SW'(s2_beat.colsum);
    hsum = t0 + (t1 << 1) + t1 + (t2 << 2) + (t3 << 1) + t3 + t4;
  end

  always_comb begin
    div_in   = s3_sum[SW-1:gb5_pkg::DIV_PRE_SHIFT];
    div_prod = PW'(div_in) * PW'(gb5_pkg::DIV_RECIP);
    quot     = div_prod[gb5_pkg::DIV_SHIFT +: gb5_pkg::PIX_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (col_ready) begin
      s2_valid <= col_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (col_ready && col_valid) begin
      s2_beat <= col_beat;
    end
    if (s2_go) begin
      cs[0] <= cs[1];
      cs[1] <= cs[2];
      cs[2] <= cs[3];
      cs[3] <= s2_beat.colsum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s2_go && s2_beat.emit) begin
      s3_valid <= 1'b1;
    end else if (o_free) begin
      s3_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go && s2_beat.emit) begin
      s3_sum    <= hsum;
      s3_margin <= s2_beat.margin;
      s3_last   <= s2_beat.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (o_free) begin
      out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (o_free && s3_valid) begin
      blurred    <= s3_margin ? '0 : quot;
      in_margin  <= s3_margin;
      frame_last <= s3_last;
    end
  end

  a_margin_is_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && in_margin) |-> (blurred == '0))
    else $error("margin beat carries a nonzero value");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (s3_valid && !o_free) |=> (s3_valid && $stable(s3_sum)))
    else $error("held sum lost while output stalled");

  a_emit_lands: assert property (@(posedge clk) disable iff (rst)
    (s2_go && s2_beat.emit) |=> s3_valid)
    else $error("emitting column did not reach the sum stage");

endmodule
